// ----- src/double_approx_equal_assert.svh -----
// assertion macros for the approximate equality block
`ifndef DOUBLE_APPROX_EQUAL_ASSERT_SVH
`define DOUBLE_APPROX_EQUAL_ASSERT_SVH

// property that must hold every cycle outside reset
`define DAE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on the next cycle
`define DAE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/dae_pkg.sv -----
// ----------------------------------------------------------------------------
// dae_pkg
// constants and helpers for double approximate equality
// ----------------------------------------------------------------------------
package dae_pkg;
    localparam int DW = 64;
    localparam int TW = 63;
    localparam logic [TW-1:0] TOL_RESET = 63'h3CB0000000000000;
    localparam logic [10:0] EXP_MAX = 11'h7FF;

    // leading one position of a 52-bit fraction, 0 when none
    function automatic logic [5:0] lead_pos(input logic [51:0] f);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 52; i++) begin
            if (f[i]) begin
                p = 6'(i);
            end
        end
        return p;
    endfunction
endpackage

// ----- src/double_approx_equal.sv -----
// path: an accepted input beat is registered with its operands in r_v1, then its result in r_v2 and r_eq
// throughput: one beat per cycle unless i_stall back-pressure raises o_stall, set by the single register stage pair
// reset: synchronous active low, clears valids and loads the default tolerance
// ----------------------------------------------------------------------------
// double_approx_equal
// tolerance-scaled approximate equality of two doubles
// ----------------------------------------------------------------------------
module double_approx_equal #(
    parameter logic [62:0] TOL_INIT = dae_pkg::TOL_RESET
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_x_bits,
    input  logic [63:0] i_y_bits,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [62:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_is_equal
);
    import dae_pkg::*;
    `include "double_approx_equal_assert.svh"

    logic [62:0] r_tol;
    logic        r_v1;
    logic [62:0] r_delta;
    logic [63:0] r_big;
    logic [63:0] r_small;
    logic        r_nan;
    logic        r_v2;
    logic        r_eq;
    logic [62:0] delta;
    logic [63:0] big;
    logic [63:0] small_op;
    logic        nan;
    logic        le;
    logic        adv2;
    logic        adv1;

    dae_front u_front (
        .i_x(i_x_bits), .i_y(i_y_bits), .i_tol(r_tol),
        .o_delta(delta), .o_big(big), .o_small(small_op), .o_nan(nan)
    );

    dae_cmp u_cmp (
        .i_big(r_big), .i_small(r_small), .i_delta(r_delta), .i_nan(r_nan), .o_le(le)
    );

    assign adv2        = !r_v2 || !i_stall;
    assign adv1        = !r_v1 || adv2;
    assign o_stall     = !adv1;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_v2;
    assign o_is_equal  = r_eq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_INIT;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_tol <= i_cfg_data;
            end
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_delta <= delta;
            r_big   <= big;
            r_small <= small_op;
            r_nan   <= nan;
        end
        if (adv2) begin
            r_eq <= le;
        end
    end

    `DAE_ASSERT(a_stall_only_full, i_clk, i_rst_n, !o_stall || (r_v1 && r_v2), "stall while not full")
    `DAE_ASSERT_NEXT(a_hold_out, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_is_equal), "result dropped")
    `DAE_ASSERT_NEXT(a_move, i_clk, i_rst_n, r_v1 && !o_stall, o_valid, "stage lost")
endmodule

// ----- src/dae_front.sv -----
// ----------------------------------------------------------------------------
// dae_front
// picks the smaller operand, scales tolerance, orders the operands by magnitude for |x-y|
// ----------------------------------------------------------------------------
module dae_front (
    input  logic [63:0] i_x,
    input  logic [63:0] i_y,
    input  logic [62:0] i_tol,
    output logic [62:0] o_delta,
    output logic [63:0] o_big,
    output logic [63:0] o_small,
    output logic        o_nan
);
    import dae_pkg::*;

    logic        x_lt;
    logic [63:0] pick;
    logic [10:0] pf;
    logic [51:0] pfr;
    logic signed [12:0] e;
    logic [10:0] tf;
    logic [52:0] tm;
    logic [5:0]  tlp;
    logic signed [13:0] tex;
    logic signed [14:0] field;
    logic [14:0] s;
    logic [52:0] q;
    logic [52:0] rmask;
    logic [52:0] rem;
    logic [52:0] half;
    logic        xnan;
    logic        ynan;

    always_comb begin
        xnan = (i_x[62:52] == EXP_MAX) && (i_x[51:0] != '0);
        ynan = (i_y[62:52] == EXP_MAX) && (i_y[51:0] != '0);
        x_lt = !xnan && !ynan && (i_x[62:0] < i_y[62:0]);
        pick = x_lt ? i_x : i_y;
        pf   = pick[62:52];
        pfr  = pick[51:0];
        if (pf == EXP_MAX) begin
            e = '0;
        end else if (pf != '0) begin
            e = 13'(signed'({2'b0, pf})) - 13'sd1022;
        end else if (pfr == '0) begin
            e = '0;
        end else begin
            e = 13'(signed'({7'b0, lead_pos(pfr)})) - 13'sd1073;
        end

        tf  = i_tol[62:52];
        tlp = lead_pos(i_tol[51:0]);
        if (tf != '0) begin
            tm  = {1'b1, i_tol[51:0]};
            tex = 14'(signed'({3'b0, tf})) - 14'sd1075;
        end else begin
            tm  = 53'(i_tol[51:0]) << (6'd52 - tlp);
            tex = 14'(signed'({8'b0, tlp})) - 14'sd1126;
        end
        field = 15'(tex) + 15'(e) + 15'sd1075;
        s     = 15'(15'sd1 - field);
        rmask = '0;
        half  = '0;
        q     = '0;
        rem   = '0;
        if (tf == EXP_MAX || i_tol == '0) begin
            o_delta = i_tol;
        end else if (field >= 15'sd2047) begin
            o_delta = {EXP_MAX, 52'b0};
        end else if (field >= 15'sd1) begin
            o_delta = {field[10:0], tm[51:0]};
        end else if (s >= 15'd55) begin
            o_delta = '0;
        end else begin
            q     = tm >> s[5:0];
            rmask = (53'd1 << s[5:0]) - 53'd1;
            rem   = tm & rmask;
            half  = 53'd1 << (s[5:0] - 6'd1);
            if (rem > half || (rem == half && q[0])) begin
                q = q + 53'd1;
            end
            o_delta = 63'(q);
        end

        o_nan = xnan || ynan
            || (i_x[62:52] == EXP_MAX && i_y[62:52] == EXP_MAX && i_x[63] == i_y[63]);
        if (i_x[62:0] >= i_y[62:0]) begin
            o_big   = i_x;
            o_small = i_y;
        end else begin
            o_big   = i_y;
            o_small = i_x;
        end
    end
endmodule

// ----- src/dae_cmp.sv -----
// ----------------------------------------------------------------------------
// dae_cmp
// correctly rounded |x-y| on registered operands, compared against delta
// ----------------------------------------------------------------------------
module dae_cmp (
    input  logic [63:0] i_big,
    input  logic [63:0] i_small,
    input  logic [62:0] i_delta,
    input  logic        i_nan,
    output logic        o_le
);
    import dae_pkg::*;

    logic [10:0] be;
    logic [10:0] se;
    logic [10:0] sh;
    logic [52:0] bm;
    logic [52:0] sm;
    logic        sub;
    logic [55:0] a_ext;
    logic [55:0] b_ext;
    logic [55:0] b_shift;
    logic [55:0] lost_mask;
    logic        sticky;
    logic [55:0] b_al;
    logic [56:0] sum;
    logic [5:0]  lz;
    logic [10:0] lshift;
    logic [55:0] nm;
    logic [11:0] nexp;
    logic        rnd;
    logic [53:0] rm;
    logic [11:0] fexp;
    logic [62:0] res;
    logic        dnan;

    always_comb begin
        be    = (i_big[62:52] == '0) ? 11'd1 : i_big[62:52];
        se    = (i_small[62:52] == '0) ? 11'd1 : i_small[62:52];
        bm    = {i_big[62:52] != '0, i_big[51:0]};
        sm    = {i_small[62:52] != '0, i_small[51:0]};
        sub   = i_big[63] == i_small[63];
        sh    = be - se;
        a_ext = {bm, 3'b0};
        b_ext = {sm, 3'b0};

        // align the smaller operand, folding shifted-out bits into a sticky bit
        if (sh > 11'd55) begin
            lost_mask = '1;
            b_shift   = '0;
            sticky    = |sm;
        end else begin
            lost_mask = (56'd1 << sh[5:0]) - 56'd1;
            b_shift   = b_ext >> sh[5:0];
            sticky    = |(b_ext & lost_mask);
        end
        b_al = b_shift | {55'b0, sticky};
        sum  = sub ? {1'b0, a_ext} - {1'b0, b_al} : {1'b0, a_ext} + {1'b0, b_al};

        lz = 6'd56;
        for (int i = 0; i < 56; i++) begin
            if (sum[i]) begin
                lz = 6'(55 - i);
            end
        end

        // normalize, stopping at the subnormal exponent
        lshift = '0;
        if (sum[56]) begin
            nm   = {sum[56:2], sum[1] | sum[0]};
            nexp = {1'b0, be} + 12'd1;
        end else begin
            lshift = (11'(lz) < be - 11'd1) ? 11'(lz) : be - 11'd1;
            nm     = sum[55:0] << lshift;
            nexp   = {1'b0, be} - {1'b0, lshift};
        end

        // round to nearest even
        rnd  = nm[2] && (nm[1] || nm[0] || nm[3]);
        rm   = {1'b0, nm[55:3]} + 54'(rnd);
        fexp = rm[53] ? nexp + 12'd1 : nexp;

        if (i_big[62:52] == EXP_MAX || fexp >= 12'd2047) begin
            res = {EXP_MAX, 52'b0};
        end else if (rm[53]) begin
            res = {fexp[10:0], 52'b0};
        end else if (rm[52]) begin
            res = {fexp[10:0], rm[51:0]};
        end else begin
            res = {11'd0, rm[51:0]};
        end

        dnan = (i_delta[62:52] == EXP_MAX) && (i_delta[51:0] != '0);
        if (i_nan || dnan) begin
            o_le = 1'b0;
        end else begin
            o_le = res <= i_delta;
        end
    end
endmodule
